>>> hw/rtl/trrs_pkg.sv
`default_nettype none
package trrs_pkg;

  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_RUN     = 3'd1;
  localparam logic [2:0] CMD_YIELD   = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_RESUME  = 3'd4;
  localparam logic [2:0] CMD_EXIT    = 3'd5;
  localparam logic [2:0] CMD_JOIN    = 3'd6;
  localparam logic [2:0] CMD_TICK    = 3'd7;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_SLOT = 2'd1;
  localparam logic [1:0] STS_INVALID = 2'd2;
  localparam logic [1:0] STS_WAIT    = 2'd3;

  localparam logic [1:0] SL_UNUSED   = 2'd0;
  localparam logic [1:0] SL_RUNNABLE = 2'd1;
  localparam logic [1:0] SL_EXITED   = 2'd2;
  localparam logic [1:0] SL_BLOCKED  = 2'd3;

  localparam logic CFG_TIMER_BIT  = 1'b0;
  localparam logic CFG_THREAD_BIT = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] channel_mask;
    logic        joinable;
    logic        only_if_needed;
    logic [63:0] exit_value;
    logic [7:0]  thread_id;
    logic [31:0] epoch_seen;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_id;
    logic        switched;
    logic [63:0] joined_value;
    logic [31:0] slot_epoch;
  } out_word_t;

endpackage
`default_nettype wire

>>> hw/rtl/trrs_ram.sv
`default_nettype none
module trrs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/trrs_front.sv
`default_nettype none
module trrs_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire trrs_pkg::in_word_t in_word,
  output logic                   busy,
  input  wire logic              q_pop,
  output logic                   q_valid,
  output trrs_pkg::in_word_t     q_word
);
  import trrs_pkg::*;

  logic     full_r, full_nxt;
  in_word_t word_r;

  assign busy    = full_r;
  assign q_valid = full_r;
  assign q_word  = word_r;

  always_comb begin
    full_nxt = full_r;
    if (q_pop) begin
      full_nxt = 1'b0;
    end
    if (start && !full_r) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
    if (start && !full_r) begin
      word_r <= in_word;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/trrs_back.sv
`default_nettype none
module trrs_back #(
  parameter int SLOT_COUNT   = 16,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire trrs_pkg::in_word_t q_word,
  output logic                    q_pop,
  input  wire logic [3:0]         timer_bit,
  input  wire logic [3:0]         thread_bit,
  output logic                    out_strobe,
  output trrs_pkg::out_word_t     out_word
);
  import trrs_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = (CHANNEL_BITS < 16) ? CHANNEL_BITS : 16;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLAIM = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_JOIN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [1:0]    sstate_r [SLOT_COUNT];
  logic [CW-1:0] wmask_r  [SLOT_COUNT];
  logic          sjoin_r  [SLOT_COUNT];
  logic [31:0]   epoch_r  [SLOT_COUNT];
  logic [SW-1:0] cur_r, idle_r, rr_r, idx_r;
  logic          idle_pres_r, resched_r;
  logic [CW-1:0] pend_r, ch_r;
  logic [31:0]   tick_r;
  logic [SW:0]   cnt_r;
  in_word_t      w_r;
  out_word_t     res_r;
  logic          strobe_r;

  logic          ram_we;
  logic [SW-1:0] ram_wa, ram_ra;
  logic [63:0]   ram_wd, ram_rd;

  trrs_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT)) u_exit_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  function automatic logic [CW-1:0] chan_of(input logic [3:0] b);
    logic [CW-1:0] r;
    r = '0;
    if (32'(b) < CW) begin
      r[b[$clog2(CW)-1:0]] = 1'b1;
    end
    return r;
  endfunction

  logic [CW-1:0] cmask;
  logic          tid_ok;
  logic [SW-1:0] tid;
  logic [SW-1:0] rr_inc;
  assign cmask  = q_word.channel_mask[CW-1:0];
  assign tid_ok = {24'd0, q_word.thread_id} < 32'(SLOT_COUNT);
  assign tid    = q_word.thread_id[SW-1:0];
  assign rr_inc = (32'(idx_r) + 1 >= SLOT_COUNT) ? '0 : idx_r + 1'b1;

  assign q_pop      = (st_r == S_IDLE) && q_valid;
  assign out_strobe = strobe_r;
  assign out_word   = res_r;

  assign ram_ra = tid;
  assign ram_we = q_pop && (q_word.command == CMD_EXIT) && idle_pres_r && (cur_r != idle_r);
  assign ram_wa = cur_r;
  assign ram_wd = q_word.exit_value;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: st_nxt = st_r;
      S_CLAIM, S_SCAN, S_JOIN, S_DONE: st_nxt = st_r;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    strobe_r <= 1'b0;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cur_r       <= '0;
      idle_r      <= '0;
      rr_r        <= '0;
      idle_pres_r <= 1'b0;
      resched_r   <= 1'b0;
      pend_r      <= '0;
      tick_r      <= '0;
      strobe_r    <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        sstate_r[i] <= SL_UNUSED;
        wmask_r[i]  <= '0;
        sjoin_r[i]  <= 1'b0;
        epoch_r[i]  <= '0;
      end
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            w_r <= q_word;
            res_r.status       <= STS_OK;
            res_r.slot_id      <= 4'(cur_r);
            res_r.switched     <= 1'b0;
            res_r.joined_value <= '0;
            res_r.slot_epoch   <= '0;
            idx_r <= '0;
            cnt_r <= '0;
            st_r  <= S_DONE;
            case (q_word.command)
              CMD_START: st_r <= S_CLAIM;
              CMD_RUN: begin
                if (idle_pres_r) res_r.status <= STS_INVALID;
                else st_r <= S_CLAIM;
              end
              CMD_YIELD: begin
                if (!idle_pres_r) begin
                  res_r.status <= STS_INVALID;
                end else if (!q_word.only_if_needed || resched_r) begin
                  if (q_word.only_if_needed) resched_r <= 1'b0;
                  ch_r <= pend_r; pend_r <= '0; idx_r <= rr_r;
                  st_r <= S_SCAN;
                end
              end
              CMD_SUSPEND: begin
                if (!idle_pres_r || cur_r == idle_r) begin
                  res_r.status <= STS_INVALID;
                end else begin
                  sstate_r[cur_r] <= SL_BLOCKED;
                  wmask_r[cur_r]  <= cmask;
                  ch_r <= pend_r; pend_r <= '0; idx_r <= rr_r;
                  st_r <= S_SCAN;
                end
              end
              CMD_RESUME: pend_r <= pend_r | cmask;
              CMD_EXIT: begin
                if (!idle_pres_r || cur_r == idle_r) begin
                  res_r.status <= STS_INVALID;
                end else begin
                  if (sjoin_r[cur_r]) begin
                    sstate_r[cur_r] <= SL_EXITED;
                    ch_r <= pend_r | chan_of(thread_bit);
                  end else begin
                    sstate_r[cur_r] <= SL_UNUSED;
                    ch_r <= pend_r;
                  end
                  pend_r <= '0; idx_r <= rr_r;
                  st_r <= S_SCAN;
                end
              end
              CMD_JOIN: begin
                if (!idle_pres_r || !tid_ok) begin
                  res_r.status <= STS_INVALID;
                end else begin
                  res_r.slot_epoch <= epoch_r[tid];
                  if (q_word.epoch_seen != 0 && q_word.epoch_seen != epoch_r[tid]) begin
                    res_r.status <= STS_INVALID;
                  end else if (sstate_r[tid] == SL_EXITED) begin
                    sstate_r[tid] <= SL_UNUSED;
                    st_r <= S_JOIN;
                  end else if (sstate_r[tid] == SL_UNUSED) begin
                    res_r.status <= STS_INVALID;
                  end else begin
                    res_r.status <= sjoin_r[tid] ? STS_WAIT : STS_INVALID;
                  end
                end
              end
              default: begin
                tick_r    <= tick_r + 32'd1;
                pend_r    <= pend_r | chan_of(timer_bit);
                resched_r <= 1'b1;
              end
            endcase
          end
        end
        S_CLAIM: begin
          if (sstate_r[idx_r] == SL_UNUSED) begin
            sstate_r[idx_r] <= SL_RUNNABLE;
            wmask_r[idx_r]  <= '0;
            sjoin_r[idx_r]  <= (w_r.command == CMD_START) && w_r.joinable;
            epoch_r[idx_r]  <= tick_r;
            res_r.slot_epoch <= tick_r;
            res_r.slot_id    <= 4'(idx_r);
            if (w_r.command == CMD_RUN) begin
              idle_r <= idx_r; idle_pres_r <= 1'b1; cur_r <= idx_r;
              res_r.switched <= 1'b1;
            end
            st_r <= S_DONE;
          end else if (32'(cnt_r) + 1 >= SLOT_COUNT) begin
            res_r.status <= STS_NO_SLOT;
            st_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SCAN: begin
          rr_r <= rr_inc;
          if (idx_r != idle_r && (sstate_r[idx_r] == SL_RUNNABLE ||
              (sstate_r[idx_r] == SL_BLOCKED && (wmask_r[idx_r] & ch_r) != '0))) begin
            if (sstate_r[idx_r] == SL_BLOCKED) begin
              sstate_r[idx_r] <= SL_RUNNABLE;
              wmask_r[idx_r]  <= '0;
            end
            cur_r <= idx_r;
            res_r.slot_id  <= 4'(idx_r);
            res_r.switched <= idx_r != cur_r;
            st_r <= S_DONE;
          end else if (32'(cnt_r) + 1 >= SLOT_COUNT) begin
            cur_r <= idle_r;
            res_r.slot_id  <= 4'(idle_r);
            res_r.switched <= idle_r != cur_r;
            st_r <= S_DONE;
          end else begin
            idx_r <= rr_inc;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_JOIN: begin
          res_r.joined_value <= ram_rd;
          st_r <= S_DONE;
        end
        S_DONE: begin
          strobe_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= st_nxt;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/thread_slot_round_robin_scheduler.sv
// Channel | Direction | Handshake
// in_     | input     | start && !busy
// out_    | output    | out_strobe, one cycle
// cfg_    | input     | cfg_valid && cfg_ready
// A word goes from the queue register through the idle and done states to its
// result; a reaping join adds a join state for the RAM read, and start, run and
// scheduling commands add the one-slot-per-cycle claim and selection scan.
// One word may wait in the queue while another runs. Reset is synchronous.
// The receiver cannot stall; each result shows for one cycle.
`default_nettype none
module thread_slot_round_robin_scheduler #(
  parameter int SLOT_COUNT   = 16,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire trrs_pkg::in_word_t in_word,
  output logic                    out_strobe,
  output trrs_pkg::out_word_t     out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [3:0]         cfg_data
);
  import trrs_pkg::*;

  logic       q_valid, q_pop;
  in_word_t   q_word;
  logic [3:0] timer_bit_r, thread_bit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_bit_r  <= 4'd0;
      thread_bit_r <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TIMER_BIT:  timer_bit_r  <= cfg_data;
        CFG_THREAD_BIT: thread_bit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  trrs_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
    .q_pop(q_pop), .q_valid(q_valid), .q_word(q_word)
  );

  trrs_back #(.SLOT_COUNT(SLOT_COUNT), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
    .timer_bit(timer_bit_r), .thread_bit(thread_bit_r),
    .out_strobe(out_strobe), .out_word(out_word)
  );
endmodule
`default_nettype wire
